### rtl/mcadc_pkg.sv
// Shared types and constants for the multichannel ADC moving-average block.
// No dependencies; imported by the top-level module of the block.
`timescale 1ns / 1ps

package mcadc_pkg;

  // Sample and window geometry
  localparam int SampleBits  = 12;
  localparam int WindowLen   = 32;
  localparam int WindowShift = 5;
  localparam int WinIdxW     = 5;
  localparam int FillW       = 6;
  localparam int SumW        = SampleBits + WindowShift;

  // Scan slots and analog mux inputs
  localparam int SlotW      = 3;
  localparam int SlotSpace  = 8;
  localparam int MuxW       = 4;
  localparam int NumMuxRegs = 5;
  localparam int ActW       = 3;

  localparam logic [MuxW-1:0] MuxReset [NumMuxRegs] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd8};
  localparam logic [ActW-1:0] ActiveReset = 3'd4;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] CfgActive  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMuxFirst = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMuxLast  = 3'd5;

  // Request codes
  typedef enum logic [1:0] {
    ReqSample  = 2'd0,
    ReqAverage = 2'd1,
    ReqLast    = 2'd2
  } req_e;

  typedef struct packed {
    req_e                  req_type;
    logic [SampleBits-1:0] sample;
    logic [SlotW-1:0]      query_channel;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0]      stored_channel;
    logic [MuxW-1:0]       next_mux_input;
    logic [SampleBits-1:0] read_value;
  } out_item_t;

endpackage

### rtl/mcadc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; holds the per-channel sample rings.
`timescale 1ns / 1ps

module mcadc_ram #(
  parameter int Width = 12,
  parameter int Depth = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/multichannel_adc_moving_average.sv
// Multichannel ADC sampler with a 32-sample boxcar average per scan slot.
// Throughput: one item per cycle unless the output stalls. Requests wait in the
// update stage until the output register is free. The ring read at transfer and
// the write from the update stage set this two-stage form. Reset: scan, counters,
// sums and values clear to zero, config registers take their reset values; the
// ring RAM is not cleared and its read data is used only once a ring is full.
`timescale 1ns / 1ps

module multichannel_adc_moving_average import mcadc_pkg::*; #(
  parameter int MAX_CHANNELS = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  localparam int ChW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RamDepth = MAX_CHANNELS * WindowLen;
  localparam int AddrW    = $clog2(RamDepth);

  // Configuration registers
  logic [ActW-1:0] active_q;
  logic [MuxW-1:0] mux_q [SlotSpace];

  // Channel state
  logic [SlotW-1:0]      scan_slot_q;
  logic [WinIdxW-1:0]    wr_idx_q [MAX_CHANNELS];
  logic [FillW-1:0]      fill_q   [MAX_CHANNELS];
  logic [SumW-1:0]       sum_q    [MAX_CHANNELS];
  logic [SampleBits-1:0] last_q   [MAX_CHANNELS];
  logic [SampleBits-1:0] avg_q    [MAX_CHANNELS];

  // Update stage registers
  logic                  s1_valid_q;
  req_e                  s1_req_q;
  logic [SampleBits-1:0] s1_smp_q;
  logic [ChW-1:0]        s1_ch_q;
  logic [SlotW-1:0]      s1_slot_q;
  logic                  s1_qok_q;
  logic [MuxW-1:0]       s1_mux_q;
  logic [AddrW-1:0]      s1_addr_q;

  // Output register
  logic      out_valid_q;
  out_item_t out_q;

  // Handshake
  logic out_ready, s1_fire, in_fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------
  // Transfer stage: pick slot, issue ring read, advance the scan
  // ---------------------------------------------------------------
  logic [SlotW:0]        act_cnt;
  logic [SlotW-1:0]      s0_slot;
  logic [SlotW:0]        s0_next_wide;
  logic [SlotW-1:0]      s0_next;
  logic                  s0_is_smp;
  logic [ChW-1:0]        s0_ch;
  logic [WinIdxW-1:0]    s0_w;
  logic [AddrW-1:0]      s0_addr;
  logic                  s0_qok;
  logic [SlotW-1:0]      s0_scan_after;
  logic [SampleBits-1:0] ram_rdata;

  always_comb begin
    // clamp the active count to 1..MAX_CHANNELS
    act_cnt = {1'b0, active_q};
    if (active_q == '0) begin
      act_cnt = (SlotW+1)'(1);
    end else if ({1'b0, active_q} > (SlotW+1)'(MAX_CHANNELS)) begin
      act_cnt = (SlotW+1)'(MAX_CHANNELS);
    end

    // a slot beyond the channel count stores into slot 0
    s0_slot = scan_slot_q;
    if ({1'b0, scan_slot_q} >= (SlotW+1)'(MAX_CHANNELS)) begin
      s0_slot = '0;
    end

    s0_next_wide = {1'b0, s0_slot} + (SlotW+1)'(1);
    s0_next      = (s0_next_wide >= act_cnt) ? '0 : s0_next_wide[SlotW-1:0];

    s0_is_smp = (in_data_i.req_type == ReqSample);
    s0_qok    = {1'b0, in_data_i.query_channel} < (SlotW+1)'(MAX_CHANNELS);
    s0_ch     = s0_is_smp ? s0_slot[ChW-1:0] : in_data_i.query_channel[ChW-1:0];
    s0_w      = wr_idx_q[s0_ch];
    s0_addr   = AddrW'({s0_slot[ChW-1:0], s0_w});

    s0_scan_after = s0_is_smp ? s0_next : scan_slot_q;
  end

  // Ring storage for all channels
  mcadc_ram #(
    .Width(SampleBits),
    .Depth(RamDepth)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (s1_fire && (s1_req_q == ReqSample)),
    .waddr_i(s1_addr_q),
    .wdata_i(s1_smp_q),
    .re_i   (in_fire && s0_is_smp),
    .raddr_i(s0_addr),
    .rdata_o(ram_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveReset;
      for (int i = 0; i < NumMuxRegs; i++) begin
        mux_q[i] <= MuxReset[i];
      end
      for (int i = NumMuxRegs; i < SlotSpace; i++) begin
        mux_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgActive) begin
        active_q <= cfg_data_i[ActW-1:0];
      end else if (cfg_idx_i >= CfgMuxFirst && cfg_idx_i <= CfgMuxLast) begin
        mux_q[cfg_idx_i - CfgMuxFirst] <= cfg_data_i[MuxW-1:0];
      end
    end
  end

  // Scan slot and write index advance at a sample transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_slot_q <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        wr_idx_q[i] <= '0;
      end
    end else if (in_fire && s0_is_smp) begin
      scan_slot_q     <= s0_next;
      wr_idx_q[s0_ch] <= s0_w + WinIdxW'(1);
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q  <= in_data_i.req_type;
      s1_smp_q  <= in_data_i.sample;
      s1_ch_q   <= s0_ch;
      s1_slot_q <= s0_slot;
      s1_qok_q  <= s0_qok;
      s1_mux_q  <= mux_q[s0_scan_after];
      s1_addr_q <= s0_addr;
    end
  end

  // ---------------------------------------------------------------
  // Update stage: running sum, average, reads
  // ---------------------------------------------------------------
  logic                  s1_full;
  logic [SumW-1:0]       sum_sub;
  logic [SumW-1:0]       sum_nxt;
  logic [SampleBits-1:0] avg_nxt;
  out_item_t             res;

  always_comb begin
    s1_full = (fill_q[s1_ch_q] == FillW'(WindowLen));

    // drop the oldest sample once the ring is full
    sum_sub = s1_full ? (sum_q[s1_ch_q] - SumW'(ram_rdata)) : sum_q[s1_ch_q];
    sum_nxt = sum_sub + SumW'(s1_smp_q);
    avg_nxt = s1_full ? SampleBits'(sum_nxt >> WindowShift) : s1_smp_q;

    res                = '0;
    res.next_mux_input = s1_mux_q;
    case (s1_req_q)
      ReqSample: begin
        res.stored_channel = s1_slot_q;
      end
      ReqAverage: begin
        if (s1_qok_q && s1_full) begin
          res.read_value = avg_q[s1_ch_q];
        end
      end
      ReqLast: begin
        if (s1_qok_q) begin
          res.read_value = last_q[s1_ch_q];
        end
      end
      default: begin
        res.stored_channel = '0;
      end
    endcase
  end

  // Channel value state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        fill_q[i] <= '0;
        sum_q[i]  <= '0;
        last_q[i] <= '0;
        avg_q[i]  <= '0;
      end
    end else if (s1_fire && (s1_req_q == ReqSample)) begin
      sum_q[s1_ch_q]  <= sum_nxt;
      avg_q[s1_ch_q]  <= avg_nxt;
      last_q[s1_ch_q] <= s1_smp_q;
      if (!s1_full) begin
        fill_q[s1_ch_q] <= fill_q[s1_ch_q] + FillW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
